// ===== hdl/lfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants for the range-sensor frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int DIST_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 4;

  // Frame bytes before the checksum: two header bytes plus six payload bytes
  localparam logic [IDX_W-1:0] FRAME_BODY_LEN = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_DIST_LOW   = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_DIST_HIGH  = IDX_W'(3);

  localparam logic [BYTE_W-1:0] HEADER_BYTE_RESET    = 8'h59;
  localparam logic [DIST_W-1:0] DISTANCE_LIMIT_RESET = 16'd100;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_byte;
    logic [DIST_W-1:0] distance_limit;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic [DIST_W-1:0] distance;
    logic              checksum_ok;
  } result_t;

endpackage

// ===== hdl/lfp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_rx_if
// Byte request channel into the frame parser.
// ----------------------------------------------------------------------------
interface lfp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [lfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/lfp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_res_if
// Result request channel out of the frame parser.
// ----------------------------------------------------------------------------
interface lfp_res_if;
  logic                      valid;
  logic                      ready;
  logic [lfp_pkg::DIST_W-1:0] distance;
  logic                      checksum_ok;

  modport source (output valid, output distance, output checksum_ok, input ready);
  modport sink   (input valid, input distance, input checksum_ok, output ready);
endinterface

// ===== hdl/lfp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface lfp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lfp_pkg::CFG_IDX_W-1:0]  index;
  logic [lfp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/lfp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_cfg_regs
// Header byte and distance limit registers.
// ----------------------------------------------------------------------------
module lfp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lfp_pkg::CFG_DATA_W-1:0] wr_data,
  output lfp_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte    <= lfp_pkg::HEADER_BYTE_RESET;
      cfg.distance_limit <= lfp_pkg::DISTANCE_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        lfp_pkg::CFG_HEADER_BYTE: begin
          cfg.header_byte <= wr_data[lfp_pkg::BYTE_W-1:0];
        end
        lfp_pkg::CFG_DISTANCE_LIMIT: begin
          cfg.distance_limit <= wr_data[lfp_pkg::DIST_W-1:0];
        end
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

endmodule

// ===== hdl/lfp_frame_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_frame_fsm
// Header hunt, payload capture, running sum and checksum verdict.
// ----------------------------------------------------------------------------
module lfp_frame_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_en,
  input  logic [lfp_pkg::BYTE_W-1:0]  rx_byte,
  input  lfp_pkg::cfg_t               cfg,
  output lfp_pkg::result_t            result
);

  lfp_pkg::phase_t              phase, phase_next;
  logic [lfp_pkg::IDX_W-1:0]    byte_index, byte_index_next;
  logic [lfp_pkg::BYTE_W-1:0]   running_sum, running_sum_next;
  logic [lfp_pkg::BYTE_W-1:0]   distance_low, distance_low_next;
  logic [lfp_pkg::BYTE_W-1:0]   distance_high, distance_high_next;
  logic [lfp_pkg::DIST_W-1:0]   raw_distance;
  logic [lfp_pkg::BYTE_W-1:0]   sum_add;
  logic [lfp_pkg::IDX_W-1:0]    index_inc;

  assign sum_add      = running_sum + rx_byte;
  assign index_inc    = byte_index + lfp_pkg::IDX_W'(1);
  assign raw_distance = {distance_high, distance_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lfp_pkg::PH_HUNT1;
      byte_index    <= '0;
      running_sum   <= '0;
      distance_low  <= '0;
      distance_high <= '0;
    end else if (byte_en) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      running_sum   <= running_sum_next;
      distance_low  <= distance_low_next;
      distance_high <= distance_high_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    running_sum_next   = running_sum;
    distance_low_next  = distance_low;
    distance_high_next = distance_high;
    result.fire        = 1'b0;
    result.distance    = '0;
    result.checksum_ok = 1'b0;
    unique case (phase)
      lfp_pkg::PH_HUNT1, lfp_pkg::PH_HUNT2: begin
        if (rx_byte == cfg.header_byte) begin
          running_sum_next = sum_add;
          byte_index_next  = index_inc;
          phase_next       = (phase == lfp_pkg::PH_HUNT1) ? lfp_pkg::PH_HUNT2
                                                          : lfp_pkg::PH_PAYLOAD;
        end else begin
          // restart the hunt; the byte is not retried as a first header
          phase_next       = lfp_pkg::PH_HUNT1;
          byte_index_next  = '0;
          running_sum_next = '0;
        end
      end
      lfp_pkg::PH_PAYLOAD: begin
        if (byte_index == lfp_pkg::IDX_DIST_LOW) begin
          distance_low_next = rx_byte;
        end else if (byte_index == lfp_pkg::IDX_DIST_HIGH) begin
          distance_high_next = rx_byte;
        end
        running_sum_next = sum_add;
        byte_index_next  = index_inc;
        if (index_inc >= lfp_pkg::FRAME_BODY_LEN) begin
          phase_next = lfp_pkg::PH_CHECK;
        end
      end
      lfp_pkg::PH_CHECK: begin
        result.fire = 1'b1;
        if (running_sum == rx_byte) begin
          result.checksum_ok = 1'b1;
          result.distance    = (raw_distance > cfg.distance_limit) ? cfg.distance_limit
                                                                   : raw_distance;
        end
        phase_next       = lfp_pkg::PH_HUNT1;
        byte_index_next  = '0;
        running_sum_next = '0;
      end
      default: begin
        phase_next = lfp_pkg::PH_HUNT1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_check_count: assert property (@(posedge clk) disable iff (rst)
    (phase == lfp_pkg::PH_CHECK) |-> (byte_index == lfp_pkg::FRAME_BODY_LEN))
    else $error("checksum phase without a full frame body");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == lfp_pkg::PH_PAYLOAD) |->
      (byte_index >= lfp_pkg::IDX_W'(2) && byte_index < lfp_pkg::FRAME_BODY_LEN))
    else $error("payload byte count out of range");

  a_hunt_count: assert property (@(posedge clk) disable iff (rst)
    (phase == lfp_pkg::PH_HUNT1) |-> (byte_index == '0 && running_sum == '0))
    else $error("hunt phase with stale frame state");

  a_fire_restart: assert property (@(posedge clk) disable iff (rst)
    (byte_en && result.fire) |=> (phase == lfp_pkg::PH_HUNT1))
    else $error("frame did not restart after a result");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result.fire |-> (result.distance <= cfg.distance_limit))
    else $error("distance above limit");
`endif

endmodule

// ===== hdl/lidar_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser_top
// Byte-serial frame parser for a range-sensor link, with result register.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle and answers each
// nine-byte frame (two header bytes, six payload bytes, one checksum byte)
// with a single result, which is registered when the checksum byte is
// accepted. Bytes are accepted in every cycle in which the result register
// is empty or its result is being taken in that same cycle, so a steady
// stream runs at one byte per cycle; only a result left waiting downstream
// holds the byte channel. The header and payload bytes produce no result.
// A byte that does not match the header while hunting restarts the hunt.
// Distance is frame byte 3 * 256 + frame byte 2, clamped to distance_limit;
// a checksum mismatch yields distance 0 with checksum_ok low. Registers
// (index 0 header_byte, reset 0x59; index 1 distance_limit, reset 100) are
// written through the configuration channel, which is always ready; writes
// to other indexes are dropped. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module lidar_frame_parser_top (
  input  logic       clk,
  input  logic       rst,
  lfp_rx_if.sink     rx,
  lfp_res_if.source  res,
  lfp_cfg_if.sink    cfg
);

  lfp_pkg::cfg_t    cfg_regs;
  lfp_pkg::result_t result;
  logic             rx_accept;
  logic             res_valid;
  logic [lfp_pkg::DIST_W-1:0] res_distance;
  logic             res_checksum_ok;

  // configuration writes are registered directly, so never stall the request
  assign cfg.ready = 1'b1;

  lfp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // advance the parser whenever the result register can take a new value
  assign rx.ready  = !res_valid || res.ready;
  assign rx_accept = rx.valid && rx.ready;

  lfp_frame_fsm u_frame_fsm (
    .clk     (clk),
    .rst     (rst),
    .byte_en (rx_accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg_regs),
    .result  (result)
  );

  // result register: load on a checksum byte, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx.ready) begin
      res_valid <= rx_accept && result.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && result.fire) begin
      res_distance    <= result.distance;
      res_checksum_ok <= result.checksum_ok;
    end
  end

  assign res.valid       = res_valid;
  assign res.distance    = res_distance;
  assign res.checksum_ok = res_checksum_ok;

endmodule

// ===== tb/sv/lidar_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser_top_tb
// Self-checking bench for the range-sensor frame parser.
// ----------------------------------------------------------------------------
// Streams bytes into the parser through the byte channel and checks every
// result against an in-bench model of the parser. The model tracks its own
// hunt/payload state, running sum and register copies. The run starts with
// hand-built frames at the reset settings. It then walks through several
// register settings with mostly well-formed random frames, mixed with noise
// bytes and broken frames. It ends with a stretch in which neither side
// stalls. Both sides insert random idle bursts elsewhere, but for every third setting.
// ----------------------------------------------------------------------------
module lidar_frame_parser_top_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_SETTINGS  = 8;
  localparam int BYTES_PER_SET = 180;
  localparam int TAIL_BYTES    = 150;

  // One parser result as the model predicts it
  typedef struct packed {
    logic [lfp_pkg::DIST_W-1:0] distance;
    logic                       checksum_ok;
  } reading_t;

  logic clk;
  logic rst;

  lfp_rx_if  rx_if ();
  lfp_res_if res_if ();
  lfp_cfg_if cfg_if ();

  lidar_frame_parser_top i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // Parser model: register copies and frame state
  logic [lfp_pkg::BYTE_W-1:0] model_header;
  logic [lfp_pkg::DIST_W-1:0] model_limit;
  lfp_pkg::phase_t            model_phase;
  logic [lfp_pkg::IDX_W-1:0]  model_index;
  logic [lfp_pkg::BYTE_W-1:0] model_sum;
  logic [lfp_pkg::BYTE_W-1:0] model_dist_lo;
  logic [lfp_pkg::BYTE_W-1:0] model_dist_hi;

  reading_t pending_readings[$];
  reading_t oldest_reading;

  int  fail_count;
  int  cycle_count;
  int  frame_bytes;
  int  res_stall_left;
  bit  idling_on;

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results pending", pending_readings.size());
      $display("lidar_frame_parser_top_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  task automatic reset_parser_model();
    model_header  = lfp_pkg::HEADER_BYTE_RESET;
    model_limit   = lfp_pkg::DISTANCE_LIMIT_RESET;
    model_phase   = lfp_pkg::PH_HUNT1;
    model_index   = '0;
    model_sum     = '0;
    model_dist_lo = '0;
    model_dist_hi = '0;
  endtask

  // Drop the frame in progress and go back to hunting the first header
  task automatic restart_hunt();
    model_phase = lfp_pkg::PH_HUNT1;
    model_index = '0;
    model_sum   = '0;
  endtask

  // Advance the model by one accepted byte; queue a reading on a checksum byte
  task automatic advance_parser(input logic [lfp_pkg::BYTE_W-1:0] b);
    reading_t                   r;
    logic [lfp_pkg::DIST_W-1:0] clamped;
    case (model_phase)
      lfp_pkg::PH_HUNT1, lfp_pkg::PH_HUNT2: begin
        if (b == model_header) begin
          model_sum   = model_sum + b;
          model_index = model_index + 1'b1;
          model_phase = (model_phase == lfp_pkg::PH_HUNT1) ? lfp_pkg::PH_HUNT2
                                                           : lfp_pkg::PH_PAYLOAD;
        end else begin
          restart_hunt();
        end
      end
      lfp_pkg::PH_PAYLOAD: begin
        if (model_index == lfp_pkg::IDX_DIST_LOW) begin
          model_dist_lo = b;
        end else if (model_index == lfp_pkg::IDX_DIST_HIGH) begin
          model_dist_hi = b;
        end
        model_sum   = model_sum + b;
        model_index = model_index + 1'b1;
        if (model_index >= lfp_pkg::FRAME_BODY_LEN) begin
          model_phase = lfp_pkg::PH_CHECK;
        end
      end
      default: begin
        clamped = {model_dist_hi, model_dist_lo};
        if (clamped > model_limit) begin
          clamped = model_limit;
        end
        r.checksum_ok = (model_sum == b);
        r.distance    = r.checksum_ok ? clamped : '0;
        pending_readings.push_back(r);
        restart_hunt();
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Byte channel
  // --------------------------------------------------------------------------
  // Offer one byte, possibly after an idle burst, and hold it until accepted
  task automatic send_byte(input logic [lfp_pkg::BYTE_W-1:0] b);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
    end
    @(negedge clk);
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    do @(posedge clk); while (!rx_if.ready);
    advance_parser(b);
  endtask

  // Send one nine-byte frame; optionally spoil its checksum
  task automatic send_frame(input logic [lfp_pkg::BYTE_W-1:0] hdr,
                            input logic [lfp_pkg::DIST_W-1:0] frame_distance,
                            input bit bad_sum);
    logic [lfp_pkg::BYTE_W-1:0] body[8];
    logic [lfp_pkg::BYTE_W-1:0] sum;
    sum     = '0;
    body[0] = hdr;
    body[1] = hdr;
    body[2] = frame_distance[7:0];
    body[3] = frame_distance[15:8];
    for (int i = 4; i < 8; i++) begin
      body[i] = lfp_pkg::BYTE_W'($urandom_range(0, 255));
    end
    for (int i = 0; i < 8; i++) begin
      sum = sum + body[i];
      send_byte(body[i]);
    end
    if (bad_sum) begin
      sum = sum ^ lfp_pkg::BYTE_W'($urandom_range(1, 255));
    end
    send_byte(sum);
    frame_bytes += 9;
  endtask

  // Lower valid, then hold until every predicted reading has come back
  task automatic wait_drained();
    @(negedge clk);
    rx_if.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Feed bytes until the model is back to hunting the first header
  task automatic flush_to_hunt();
    while (model_phase != lfp_pkg::PH_HUNT1) begin
      if (model_phase == lfp_pkg::PH_HUNT2) begin
        send_byte(~model_header);
      end else begin
        send_byte(lfp_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Configuration channel
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [lfp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lfp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == lfp_pkg::CFG_HEADER_BYTE) begin
      model_header = data[lfp_pkg::BYTE_W-1:0];
    end else if (idx == lfp_pkg::CFG_DISTANCE_LIMIT) begin
      model_limit = data;
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready stalls at the falling edge, checks at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (res_stall_left > 0) begin
      res_stall_left--;
      res_if.ready = 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      res_stall_left = $urandom_range(0, 12);
      res_if.ready   = 1'b0;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance=%0d checksum_ok=%0b",
                                  res_if.distance, res_if.checksum_ok));
      end else begin
        oldest_reading = pending_readings.pop_front();
        if (res_if.distance !== oldest_reading.distance) begin
          report_mismatch($sformatf("distance got %0d want %0d",
                                    res_if.distance, oldest_reading.distance));
        end
        if (res_if.checksum_ok !== oldest_reading.checksum_ok) begin
          report_mismatch($sformatf("checksum_ok got %0b want %0b",
                                    res_if.checksum_ok, oldest_reading.checksum_ok));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Pick a distance that lands on, just past or just short of the limit, or a random one
  function automatic logic [lfp_pkg::DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 4))
      0:       return model_limit;
      1:       return model_limit + 1'b1;
      2:       return model_limit - 1'b1;
      default: return lfp_pkg::DIST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One unit of random traffic: mostly frames, some noise and broken frames
  task automatic send_random_unit();
    int                         kind;
    int                         cut;
    logic [lfp_pkg::BYTE_W-1:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_frame(model_header, pick_distance(), $urandom_range(0, 9) == 0);
    end else if (kind < 85) begin
      // noise: a random byte, sometimes the header itself
      b = ($urandom_range(0, 3) == 0) ? model_header
                                      : lfp_pkg::BYTE_W'($urandom_range(0, 255));
      send_byte(b);
    end else if (kind < 92) begin
      // bad second header
      send_byte(model_header);
      send_byte(~model_header);
      frame_bytes += 2;
    end else begin
      // truncated frame: the bytes that follow run on as its payload
      cut = $urandom_range(0, 5);
      send_byte(model_header);
      send_byte(model_header);
      repeat (cut) send_byte(lfp_pkg::BYTE_W'($urandom_range(0, 255)));
      frame_bytes += 2 + cut;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: limit edge, clamp, bad checksum, bad first and second header
  task automatic test_default_frames();
    send_frame(lfp_pkg::HEADER_BYTE_RESET, lfp_pkg::DISTANCE_LIMIT_RESET, 1'b0);
    send_frame(lfp_pkg::HEADER_BYTE_RESET, 16'hFFFF, 1'b0);
    send_frame(lfp_pkg::HEADER_BYTE_RESET, 16'h0000, 1'b1);
    send_byte(8'h00);
    send_byte(lfp_pkg::HEADER_BYTE_RESET);
    send_byte(8'hA6);
    send_frame(lfp_pkg::HEADER_BYTE_RESET, 16'h0063, 1'b0);
  endtask

  // Walk through register settings, reset values and extremes first, then random ones
  task automatic test_random_settings();
    logic [lfp_pkg::BYTE_W-1:0] hdr;
    logic [lfp_pkg::DIST_W-1:0] lim;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: begin
          hdr = lfp_pkg::HEADER_BYTE_RESET;
          lim = lfp_pkg::DISTANCE_LIMIT_RESET;
        end
        1: begin hdr = 8'h00; lim = 16'h0000; end
        2: begin hdr = 8'hFF; lim = 16'hFFFF; end
        3: begin hdr = 8'h59; lim = lfp_pkg::DIST_W'($urandom_range(0, 255)); end
        default: begin
          hdr = lfp_pkg::BYTE_W'($urandom_range(0, 255));
          lim = lfp_pkg::DIST_W'($urandom_range(0, 65535));
        end
      endcase
      // quiesce the parser before touching its registers
      flush_to_hunt();
      wait_drained();
      write_register(lfp_pkg::CFG_HEADER_BYTE,
                     {lfp_pkg::CFG_DATA_W'($urandom_range(0, 255)) << lfp_pkg::BYTE_W} | hdr);
      write_register(lfp_pkg::CFG_DISTANCE_LIMIT, lim);
      // drop writes to unused indexes, the top index among them
      if (s == 1) begin
        write_register(8'hFF, lfp_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 1) == 0) begin
        write_register(lfp_pkg::CFG_IDX_W'($urandom_range(2, 254)),
                       lfp_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
      end
      // leave one setting of every three without stalls
      idling_on   = (s % 3 != 2);
      frame_bytes = 0;
      while (frame_bytes < BYTES_PER_SET) begin
        send_random_unit();
      end
    end
  endtask

  // Back-to-back frames with no stalls on either side
  task automatic test_back_to_back();
    idling_on   = 1'b0;
    frame_bytes = 0;
    while (frame_bytes < TAIL_BYTES) begin
      send_random_unit();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;
    res_stall_left = 0;
    idling_on      = 1'b1;
    fail_count     = 0;
    cycle_count    = 0;
    frame_bytes    = 0;
    reset_parser_model();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_frames();
    // hold the byte stream until every reading is back
    wait_drained();
    test_random_settings();
    test_back_to_back();

    // drain the results, then idle a little before the verdict
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("lidar_frame_parser_top_tb OK");
    end else begin
      $display("lidar_frame_parser_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lfp_pkg.sv
hdl/lfp_rx_if.sv
hdl/lfp_res_if.sv
hdl/lfp_cfg_if.sv
hdl/lfp_cfg_regs.sv
hdl/lfp_frame_fsm.sv
hdl/lidar_frame_parser_top.sv
tb/sv/lidar_frame_parser_top_tb.sv
